[design/eph_pkg.sv]
// Package for the echo probe health monitor.
// Holds field widths, result kind codes and the configuration struct.
// No dependencies; every other design file uses it.
package eph_pkg;

  localparam int unsigned IdW    = 15;
  localparam int unsigned SeqW   = 15;
  localparam int unsigned StampW = 32;
  localparam int unsigned AttW   = 8;
  localparam int unsigned IvalW  = 16;
  localparam int unsigned KindW  = 2;
  localparam int unsigned RtypeW = 8;
  localparam int unsigned AddrW  = 4;
  localparam int unsigned DataW  = 32;

  localparam logic [SeqW-1:0] SeqMax = 15'h7fff;
  localparam logic [AttW-1:0] AttMax = 8'hff;

  localparam logic [KindW-1:0] KindProbe   = 2'd0;
  localparam logic [KindW-1:0] KindSuccess = 2'd1;
  localparam logic [KindW-1:0] KindFailure = 2'd2;

  localparam logic ReqTick  = 1'b0;
  localparam logic ReqReply = 1'b1;

  localparam logic [RtypeW-1:0] RtypeEchoReply = 8'd0;

  localparam logic [1:0] RegPoll = 2'd0;
  localparam logic [1:0] RegWait = 2'd1;
  localparam logic [1:0] RegMax  = 2'd2;

  typedef struct packed {
    logic [IvalW-1:0] poll_ival;
    logic [IvalW-1:0] wait_ival;
    logic [AttW-1:0]  max_att;
  } cfg_t;

endpackage

[design/eph_if.sv]
// Valid/ready channel interfaces for the echo probe health monitor.
// Depends on eph_pkg for the payload widths.
interface eph_in_if;
  logic                        valid;
  logic                        ready;
  logic                        req_type;
  logic [eph_pkg::IdW-1:0]     fresh_id;
  logic [eph_pkg::RtypeW-1:0]  reply_type;
  logic [eph_pkg::IdW-1:0]     reply_id;
  logic [eph_pkg::StampW-1:0]  reply_stamp;

  modport source (output valid, req_type, fresh_id, reply_type, reply_id, reply_stamp,
                  input ready);
  modport sink (input valid, req_type, fresh_id, reply_type, reply_id, reply_stamp,
                output ready);
endinterface

interface eph_out_if;
  logic                        valid;
  logic                        ready;
  logic [eph_pkg::KindW-1:0]   out_kind;
  logic [eph_pkg::IdW-1:0]     probe_ident;
  logic [eph_pkg::SeqW-1:0]    probe_seq;
  logic [eph_pkg::StampW-1:0]  send_stamp;
  logic [eph_pkg::StampW-1:0]  round_trip;
  logic [eph_pkg::AttW-1:0]    attempt_number;

  modport source (output valid, out_kind, probe_ident, probe_seq, send_stamp, round_trip,
                  attempt_number, input ready);
  modport sink (input valid, out_kind, probe_ident, probe_seq, send_stamp, round_trip,
                attempt_number, output ready);
endinterface

[design/eph_cfg.sv]
// APB-style register file holding poll interval, wait interval and max attempts.
// Depends on eph_pkg for the register map and the configuration struct.
module eph_cfg (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [eph_pkg::AddrW-1:0]  paddr,
  input  logic [eph_pkg::DataW-1:0]  pwdata,
  output logic [eph_pkg::DataW-1:0]  prdata,
  output logic                       pready,
  output eph_pkg::cfg_t              cfg
);

  eph_pkg::cfg_t cfg_r;
  eph_pkg::cfg_t cfg_nxt;
  logic          wr_en;
  logic [1:0]    reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_idx = paddr[3:2];

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (reg_idx)
        eph_pkg::RegPoll: cfg_nxt.poll_ival = pwdata[eph_pkg::IvalW-1:0];
        eph_pkg::RegWait: cfg_nxt.wait_ival = pwdata[eph_pkg::IvalW-1:0];
        eph_pkg::RegMax:  cfg_nxt.max_att   = pwdata[eph_pkg::AttW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      eph_pkg::RegPoll: prdata = {{(eph_pkg::DataW-eph_pkg::IvalW){1'b0}}, cfg_r.poll_ival};
      eph_pkg::RegWait: prdata = {{(eph_pkg::DataW-eph_pkg::IvalW){1'b0}}, cfg_r.wait_ival};
      eph_pkg::RegMax:  prdata = {{(eph_pkg::DataW-eph_pkg::AttW){1'b0}}, cfg_r.max_att};
      default:          prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.poll_ival <= 16'd15;
      cfg_r.wait_ival <= 16'd3;
      cfg_r.max_att   <= 8'd5;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

[design/eph_core.sv]
// Probe sequencer: input register, state update logic and result register.
// Depends on eph_pkg and the channel interfaces in eph_if.
module eph_core #(
  parameter int unsigned ID_BITS = 15
) (
  input  logic              clk,
  input  logic              rst_n,
  input  eph_pkg::cfg_t     cfg,
  eph_in_if.sink            in_ch,
  eph_out_if.source         out_ch
);

  localparam logic [1:0] PhIdle  = 2'd0;
  localparam logic [1:0] PhWait  = 2'd1;
  localparam logic [1:0] PhSleep = 2'd2;

  // Input register.
  logic                         s1_valid_r, s1_valid_nxt;
  logic                         s1_req_r;
  logic [eph_pkg::IdW-1:0]      s1_fresh_r;
  logic [eph_pkg::RtypeW-1:0]   s1_rtype_r;
  logic [eph_pkg::IdW-1:0]      s1_rid_r;
  logic [eph_pkg::StampW-1:0]   s1_rstamp_r;

  // Prober state.
  logic [1:0]                   phase_r, phase_nxt;
  logic [eph_pkg::IvalW-1:0]    cnt_r, cnt_nxt;
  logic [eph_pkg::AttW-1:0]     att_r, att_nxt;
  logic [ID_BITS-1:0]           ident_r, ident_nxt;
  logic [eph_pkg::SeqW-1:0]     seq_r, seq_nxt;
  logic [eph_pkg::StampW-1:0]   tick_r, tick_nxt;

  // Result register.
  logic                         out_valid_r, out_valid_nxt;
  logic [eph_pkg::KindW-1:0]    kind_r;
  logic [eph_pkg::IdW-1:0]      pid_r;
  logic [eph_pkg::SeqW-1:0]     pseq_r;
  logic [eph_pkg::StampW-1:0]   stamp_r;
  logic [eph_pkg::StampW-1:0]   rtt_r;
  logic [eph_pkg::AttW-1:0]     attn_r;

  logic                         in_fire, out_free, s1_fire;
  logic                         res_v;
  logic [eph_pkg::KindW-1:0]    res_kind;
  logic [eph_pkg::IdW-1:0]      res_pid;
  logic [eph_pkg::SeqW-1:0]     res_seq;
  logic [eph_pkg::StampW-1:0]   res_stamp;
  logic [eph_pkg::StampW-1:0]   res_rtt;
  logic [eph_pkg::AttW-1:0]     res_att;

  function automatic logic [ID_BITS-1:0] to_id(input logic [eph_pkg::IdW-1:0] v);
    logic [ID_BITS-1:0] r;
    for (int i = 0; i < ID_BITS; i++) begin
      r[i] = (i < eph_pkg::IdW) ? v[i] : 1'b0;
    end
    return r;
  endfunction

  function automatic logic [eph_pkg::IdW-1:0] from_id(input logic [ID_BITS-1:0] v);
    logic [eph_pkg::IdW-1:0] r;
    for (int i = 0; i < eph_pkg::IdW; i++) begin
      r[i] = (i < ID_BITS) ? v[i] : 1'b0;
    end
    return r;
  endfunction

  assign out_free    = !out_valid_r || out_ch.ready;
  assign s1_fire     = s1_valid_r && out_free;
  assign in_ch.ready = !s1_valid_r || out_free;
  assign in_fire     = in_ch.valid && in_ch.ready;

  assign s1_valid_nxt  = in_fire ? 1'b1 : (s1_fire ? 1'b0 : s1_valid_r);
  assign out_valid_nxt = out_free ? (s1_fire && res_v) : out_valid_r;

  always_comb begin
    logic                      do_probe;
    logic [eph_pkg::AttW-1:0]  att_base;
    do_probe   = 1'b0;
    att_base   = att_r;
    phase_nxt  = phase_r;
    cnt_nxt    = cnt_r;
    att_nxt    = att_r;
    ident_nxt  = ident_r;
    seq_nxt    = seq_r;
    tick_nxt   = tick_r;
    res_v      = 1'b0;
    res_kind   = eph_pkg::KindProbe;
    res_pid    = from_id(ident_r);
    res_seq    = '0;
    res_stamp  = '0;
    res_rtt    = '0;
    res_att    = att_r;
    if (s1_fire) begin
      if (s1_req_r == eph_pkg::ReqTick) begin
        tick_nxt = tick_r + 32'd1;
        if (phase_r == PhWait) begin
          if (cnt_r > 16'd1) begin
            cnt_nxt = cnt_r - 16'd1;
          end else if (att_r >= cfg.max_att || att_r == eph_pkg::AttMax) begin
            res_v     = 1'b1;
            res_kind  = eph_pkg::KindFailure;
            cnt_nxt   = cfg.poll_ival;
            phase_nxt = PhSleep;
          end else begin
            do_probe = 1'b1;
          end
        end else if (phase_r == PhSleep && cnt_r > 16'd1) begin
          cnt_nxt = cnt_r - 16'd1;
        end else begin
          do_probe  = 1'b1;
          att_base  = '0;
          ident_nxt = to_id(s1_fresh_r);
        end
      end else if (phase_r == PhWait && s1_rtype_r == eph_pkg::RtypeEchoReply &&
                   to_id(s1_rid_r) == ident_r) begin
        res_v     = 1'b1;
        res_kind  = eph_pkg::KindSuccess;
        res_rtt   = tick_r - s1_rstamp_r;
        cnt_nxt   = cfg.poll_ival;
        phase_nxt = PhSleep;
      end
      if (do_probe) begin
        att_nxt   = att_base + 8'd1;
        seq_nxt   = (seq_r >= eph_pkg::SeqMax) ? 15'd1 : seq_r + 15'd1;
        cnt_nxt   = cfg.wait_ival;
        phase_nxt = PhWait;
        res_v     = 1'b1;
        res_kind  = eph_pkg::KindProbe;
        res_pid   = from_id(ident_nxt);
        res_seq   = seq_r;
        res_stamp = tick_nxt;
        res_att   = att_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      phase_r     <= PhIdle;
      cnt_r       <= '0;
      att_r       <= '0;
      ident_r     <= '0;
      seq_r       <= 15'd1;
      tick_r      <= '0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      phase_r     <= phase_nxt;
      cnt_r       <= cnt_nxt;
      att_r       <= att_nxt;
      ident_r     <= ident_nxt;
      seq_r       <= seq_nxt;
      tick_r      <= tick_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_req_r    <= in_ch.req_type;
      s1_fresh_r  <= in_ch.fresh_id;
      s1_rtype_r  <= in_ch.reply_type;
      s1_rid_r    <= in_ch.reply_id;
      s1_rstamp_r <= in_ch.reply_stamp;
    end
    if (s1_fire && res_v) begin
      kind_r  <= res_kind;
      pid_r   <= res_pid;
      pseq_r  <= res_seq;
      stamp_r <= res_stamp;
      rtt_r   <= res_rtt;
      attn_r  <= res_att;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.out_kind       = kind_r;
  assign out_ch.probe_ident    = pid_r;
  assign out_ch.probe_seq      = pseq_r;
  assign out_ch.send_stamp     = stamp_r;
  assign out_ch.round_trip     = rtt_r;
  assign out_ch.attempt_number = attn_r;

  a_phase_legal: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r != 2'd3) else $error("phase reached unused code");

  a_kind_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (kind_r == eph_pkg::KindProbe || kind_r == eph_pkg::KindSuccess ||
                     kind_r == eph_pkg::KindFailure)) else $error("illegal result kind");

  a_probe_waits: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_fire && res_v && res_kind == eph_pkg::KindProbe) |=> phase_r == PhWait)
    else $error("probe did not enter the wait phase");

  a_report_sleeps: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_fire && res_v && res_kind != eph_pkg::KindProbe) |=> phase_r == PhSleep)
    else $error("report did not enter the sleep phase");

  a_seq_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    seq_r != '0) else $error("sequence number reached zero");

endmodule

[design/echo_probe_health_monitor.sv]
// The echo probe health monitor accepts one word per clock cycle on its input channel unless
// a waiting result stalls it, and passes each result through the input register and then the
// result register, with the state update done in a single pass between them. A tick
// or reply that produces no result leaves nothing on the output channel. The output register
// separates the two sides, so a word is taken while a result waits as long as the input
// register is empty. Configuration is written through the APB port.
module echo_probe_health_monitor #(
  parameter int unsigned ID_BITS = 15
) (
  input  logic                       clk,
  input  logic                       rst_n,
  eph_in_if.sink                     in_ch,
  eph_out_if.source                  out_ch,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [eph_pkg::AddrW-1:0]  paddr,
  input  logic [eph_pkg::DataW-1:0]  pwdata,
  output logic [eph_pkg::DataW-1:0]  prdata,
  output logic                       pready
);

  eph_pkg::cfg_t cfg;

  eph_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  eph_core #(
    .ID_BITS (ID_BITS)
  ) u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg    (cfg),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

endmodule

[dv/tb_echo_probe_health_monitor.sv]
`timescale 1ns / 1ps
// Testbench for the echo probe health monitor: sends tick and reply words, predicts each
// probe, success and failure report, and compares the result words field by field.
// Depends on eph_pkg, the channel interfaces in eph_if.sv and the echo_probe_health_monitor top.
module tb_echo_probe_health_monitor;

  localparam logic [1:0] PhIdle  = 2'd0;
  localparam logic [1:0] PhWait  = 2'd1;
  localparam logic [1:0] PhSleep = 2'd2;

  localparam logic [1:0] RegUnused = 2'd3;

  typedef struct packed {
    logic [eph_pkg::KindW-1:0]  kind;
    logic [eph_pkg::IdW-1:0]    ident;
    logic [eph_pkg::SeqW-1:0]   seq;
    logic [eph_pkg::StampW-1:0] stamp;
    logic [eph_pkg::StampW-1:0] rtt;
    logic [eph_pkg::AttW-1:0]   att;
  } probe_report_t;

  logic                      clk = 1'b0;
  logic                      rst_n;
  logic                      psel;
  logic                      penable;
  logic                      pwrite;
  logic [eph_pkg::AddrW-1:0] paddr;
  logic [eph_pkg::DataW-1:0] pwdata;
  logic [eph_pkg::DataW-1:0] prdata;
  logic                      pready;

  eph_in_if  in_ch();
  eph_out_if out_ch();

  echo_probe_health_monitor dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  eph_pkg::cfg_t              cfg_shadow;
  logic [1:0]                 mon_phase;
  logic [eph_pkg::IvalW-1:0]  countdown_q;
  logic [eph_pkg::AttW-1:0]   att_sent;
  logic [eph_pkg::IdW-1:0]    cyc_id;
  logic [eph_pkg::SeqW-1:0]   next_seq;
  logic [eph_pkg::StampW-1:0] tick_count;
  logic [eph_pkg::StampW-1:0] last_probe_stamp;
  bit                         probe_out;
  probe_report_t              expected_reports[$];

  int mismatches;
  bit steady;
  int hold_request;
  int hold_left = 0;

  function automatic void push_report(logic [eph_pkg::KindW-1:0] kind,
                                      logic [eph_pkg::SeqW-1:0] seq,
                                      logic [eph_pkg::StampW-1:0] stamp,
                                      logic [eph_pkg::StampW-1:0] rtt);
    probe_report_t r;
    r.kind  = kind;
    r.ident = cyc_id;
    r.seq   = seq;
    r.stamp = stamp;
    r.rtt   = rtt;
    r.att   = att_sent;
    expected_reports.push_back(r);
  endfunction

  function automatic void emit_probe();
    logic [eph_pkg::SeqW-1:0] seq;
    seq = next_seq;
    att_sent = att_sent + 1'b1;
    next_seq = (next_seq >= eph_pkg::SeqMax) ? eph_pkg::SeqW'(1) : next_seq + 1'b1;
    countdown_q = cfg_shadow.wait_ival;
    mon_phase = PhWait;
    last_probe_stamp = tick_count;
    probe_out = 1'b1;
    push_report(eph_pkg::KindProbe, seq, tick_count, '0);
  endfunction

  function automatic void predict_word(logic rt, logic [eph_pkg::IdW-1:0] fid,
                                       logic [eph_pkg::RtypeW-1:0] rtyp,
                                       logic [eph_pkg::IdW-1:0] rid,
                                       logic [eph_pkg::StampW-1:0] rstamp);
    probe_out = 1'b0;
    if (rt == eph_pkg::ReqTick) begin
      tick_count = tick_count + 1'b1;
      if ((mon_phase == PhWait || mon_phase == PhSleep) && countdown_q > 1) begin
        countdown_q = countdown_q - 1'b1;
      end else if (mon_phase == PhWait &&
                   (att_sent >= cfg_shadow.max_att || att_sent == eph_pkg::AttMax)) begin
        push_report(eph_pkg::KindFailure, '0, '0, '0);
        countdown_q = cfg_shadow.poll_ival;
        mon_phase = PhSleep;
      end else begin
        if (mon_phase != PhWait) begin
          cyc_id = fid;
          att_sent = '0;
        end
        emit_probe();
      end
    end else if (mon_phase == PhWait && rtyp == eph_pkg::RtypeEchoReply && rid == cyc_id) begin
      push_report(eph_pkg::KindSuccess, '0, '0, tick_count - rstamp);
      countdown_q = cfg_shadow.poll_ival;
      mon_phase = PhSleep;
    end
  endfunction

  function automatic void check_field(string fname, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      mismatches++;
      $display("%0t: %s expected %0h, actual %0h", $time, fname, want, got);
    end
  endfunction

  function automatic void check_report();
    probe_report_t want;
    if (expected_reports.size() == 0) begin
      mismatches++;
      $display("%0t: result word with none expected, kind expected none, actual %0h",
               $time, out_ch.out_kind);
      return;
    end
    want = expected_reports.pop_front();
    check_field("out_kind", 32'(want.kind), 32'(out_ch.out_kind));
    check_field("probe_ident", 32'(want.ident), 32'(out_ch.probe_ident));
    check_field("probe_seq", 32'(want.seq), 32'(out_ch.probe_seq));
    check_field("send_stamp", want.stamp, out_ch.send_stamp);
    check_field("round_trip", want.rtt, out_ch.round_trip);
    check_field("attempt_number", 32'(want.att), 32'(out_ch.attempt_number));
  endfunction

  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      check_report();
    end
    if (hold_request > 0) begin
      hold_left = hold_request;
      hold_request = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= steady || ($urandom_range(99) >= 27);
    end
  end

  task automatic send_word(input logic rt, input logic [eph_pkg::IdW-1:0] fid,
                           input logic [eph_pkg::RtypeW-1:0] rtyp,
                           input logic [eph_pkg::IdW-1:0] rid,
                           input logic [eph_pkg::StampW-1:0] rstamp);
    if (!steady && $urandom_range(99) < 27) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.req_type    <= rt;
    in_ch.fresh_id    <= fid;
    in_ch.reply_type  <= rtyp;
    in_ch.reply_id    <= rid;
    in_ch.reply_stamp <= rstamp;
    @(posedge clk);
    while (in_ch.ready !== 1'b1) @(posedge clk);
    predict_word(rt, fid, rtyp, rid, rstamp);
  endtask

  task automatic send_tick();
    send_word(eph_pkg::ReqTick, eph_pkg::IdW'($urandom), eph_pkg::RtypeW'($urandom),
              eph_pkg::IdW'($urandom), $urandom);
  endtask

  task automatic send_reply(input logic [eph_pkg::RtypeW-1:0] rtyp,
                            input logic [eph_pkg::IdW-1:0] rid,
                            input logic [eph_pkg::StampW-1:0] rstamp);
    send_word(eph_pkg::ReqReply, eph_pkg::IdW'($urandom), rtyp, rid, rstamp);
  endtask

  task automatic tick_until_probe();
    do send_tick(); while (!probe_out);
  endtask

  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    while (expected_reports.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  function automatic logic [eph_pkg::DataW-1:0] shadow_reg(logic [1:0] idx);
    case (idx)
      eph_pkg::RegPoll: return eph_pkg::DataW'(cfg_shadow.poll_ival);
      eph_pkg::RegWait: return eph_pkg::DataW'(cfg_shadow.wait_ival);
      eph_pkg::RegMax:  return eph_pkg::DataW'(cfg_shadow.max_att);
      default:          return '0;
    endcase
  endfunction

  task automatic cfg_read_check(input logic [1:0] idx);
    logic [eph_pkg::DataW-1:0] got;
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {idx, 2'b00};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (pready !== 1'b1) @(posedge clk);
    got = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    if (got !== shadow_reg(idx)) begin
      mismatches++;
      $display("%0t: register %0d expected %0h, actual %0h", $time, idx, shadow_reg(idx), got);
    end
  endtask

  task automatic cfg_write(input logic [1:0] idx, input logic [eph_pkg::DataW-1:0] val);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (pready !== 1'b1) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    case (idx)
      eph_pkg::RegPoll: cfg_shadow.poll_ival = val[eph_pkg::IvalW-1:0];
      eph_pkg::RegWait: cfg_shadow.wait_ival = val[eph_pkg::IvalW-1:0];
      eph_pkg::RegMax:  cfg_shadow.max_att   = val[eph_pkg::AttW-1:0];
      default: ;
    endcase
    if (idx != RegUnused) cfg_read_check(idx);
  endtask

  task automatic set_config(input logic [eph_pkg::IvalW-1:0] poll,
                            input logic [eph_pkg::IvalW-1:0] wait_t,
                            input logic [eph_pkg::AttW-1:0] max_t);
    wait_idle();
    cfg_write(eph_pkg::RegPoll, eph_pkg::DataW'(poll));
    cfg_write(eph_pkg::RegWait, eph_pkg::DataW'(wait_t));
    cfg_write(eph_pkg::RegMax, eph_pkg::DataW'(max_t));
  endtask

  task automatic test_reset_values();
    cfg_read_check(eph_pkg::RegPoll);
    cfg_read_check(eph_pkg::RegWait);
    cfg_read_check(eph_pkg::RegMax);
  endtask

  task automatic test_directed_cases();
    set_config(16'd2, 16'd1, 8'd2);
    send_reply(eph_pkg::RtypeEchoReply, cyc_id, 32'h0);
    send_word(eph_pkg::ReqTick, 15'h7fff, 8'hff, 15'h7fff, 32'hffff_ffff);
    send_reply(8'hff, cyc_id, last_probe_stamp);
    send_reply(8'h01, cyc_id, last_probe_stamp);
    send_reply(eph_pkg::RtypeEchoReply, cyc_id ^ 15'h4000, last_probe_stamp);
    send_reply(eph_pkg::RtypeEchoReply, 15'h0, last_probe_stamp);
    send_reply(eph_pkg::RtypeEchoReply, cyc_id, 32'hffff_ffff);
    send_reply(eph_pkg::RtypeEchoReply, cyc_id, 32'h0);
    send_tick();
    send_word(eph_pkg::ReqTick, 15'h0, 8'h0, 15'h0, 32'h0);
    send_tick();
    send_tick();
    send_reply(eph_pkg::RtypeEchoReply, cyc_id, last_probe_stamp);
    send_tick();
    send_tick();
    send_reply(eph_pkg::RtypeEchoReply, cyc_id, 32'h0);
    wait_idle();
    cfg_write(RegUnused, 32'hffff_ffff);
    send_tick();
    send_tick();
  endtask

  task automatic test_zero_settings();
    set_config(16'd0, 16'd0, 8'd0);
    tick_until_probe();
    send_tick();
    send_tick();
    send_reply(eph_pkg::RtypeEchoReply, cyc_id, last_probe_stamp);
    send_tick();
    send_tick();
  endtask

  task automatic test_attempt_ceiling();
    set_config(16'd1, 16'd1, 8'd255);
    steady = 1'b1;
    tick_until_probe();
    while (mon_phase == PhWait) send_tick();
    steady = 1'b0;
  endtask

  task automatic test_output_stall();
    set_config(16'd1, 16'd1, 8'd3);
    hold_request = 300;
    repeat (60) send_tick();
    wait_idle();
    repeat (10) send_tick();
  endtask

  task automatic test_long_intervals();
    set_config(16'd2, 16'hffff, 8'd255);
    tick_until_probe();
    repeat (100) send_tick();
    send_reply(eph_pkg::RtypeEchoReply, cyc_id, last_probe_stamp);
    set_config(16'd1, 16'd1, 8'd255);
    while (mon_phase == PhSleep) send_tick();
    send_tick();
  endtask

  task automatic test_random_traffic();
    int pick;
    int noise;
    logic [eph_pkg::StampW-1:0] echo;
    for (int p = 0; p < 6; p++) begin
      set_config(eph_pkg::IvalW'($urandom_range(1, 6)),
                 (p == 3) ? eph_pkg::IvalW'($urandom_range(8, 20)) :
                            eph_pkg::IvalW'($urandom_range(1, 5)),
                 eph_pkg::AttW'($urandom_range(1, 4)));
      for (int n = 0; n < 200; n++) begin
        pick = $urandom_range(99);
        echo = ($urandom_range(3) == 0) ? $urandom : last_probe_stamp;
        if (pick < 55) begin
          send_tick();
        end else if (pick < 85) begin
          send_reply(eph_pkg::RtypeEchoReply, cyc_id, echo);
        end else begin
          noise = $urandom_range(2);
          case (noise)
            0: begin
              send_reply(eph_pkg::RtypeW'($urandom_range(1, 255)), cyc_id, echo);
            end
            1: begin
              send_reply(eph_pkg::RtypeEchoReply,
                         cyc_id ^ (eph_pkg::IdW'(1) << $urandom_range(eph_pkg::IdW - 1)),
                         echo);
            end
            default: begin
              send_reply(eph_pkg::RtypeW'($urandom), eph_pkg::IdW'($urandom), $urandom);
            end
          endcase
        end
      end
    end
  endtask

  initial begin
    #20_000_000;
    $display("tb_echo_probe_health_monitor: done, errors");
    $finish;
  end

  initial begin
    rst_n             <= 1'b0;
    psel              <= 1'b0;
    penable           <= 1'b0;
    pwrite            <= 1'b0;
    paddr             <= '0;
    pwdata            <= '0;
    in_ch.valid       <= 1'b0;
    in_ch.req_type    <= eph_pkg::ReqTick;
    in_ch.fresh_id    <= '0;
    in_ch.reply_type  <= '0;
    in_ch.reply_id    <= '0;
    in_ch.reply_stamp <= '0;
    mismatches   = 0;
    steady       = 1'b0;
    hold_request = 0;
    cfg_shadow.poll_ival = 16'd15;
    cfg_shadow.wait_ival = 16'd3;
    cfg_shadow.max_att   = 8'd5;
    mon_phase        = PhIdle;
    countdown_q      = '0;
    att_sent         = '0;
    cyc_id           = '0;
    next_seq         = eph_pkg::SeqW'(1);
    tick_count       = '0;
    last_probe_stamp = '0;
    probe_out        = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_values();
    test_directed_cases();
    test_zero_settings();
    test_attempt_ceiling();
    test_output_stall();
    test_long_intervals();
    test_random_traffic();

    in_ch.valid <= 1'b0;
    for (int n = 0; n < 100000 && expected_reports.size() != 0; n++) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatches == 0 && expected_reports.size() == 0) begin
      $display("tb_echo_probe_health_monitor: done, clean");
    end else begin
      $display("tb_echo_probe_health_monitor: done, errors");
    end
    $finish;
  end

endmodule

[echo_probe_health_monitor.f]
design/eph_pkg.sv
design/eph_if.sv
design/eph_cfg.sv
design/eph_core.sv
design/echo_probe_health_monitor.sv
dv/tb_echo_probe_health_monitor.sv
